FILE: rtl/core/cpsr_pkg.sv
// Shared types and constants for the checkpoint slot table.
// No dependencies; imported by every module of the block.
package cpsr_pkg;

   localparam int MAX_SLOTS_DEF = 16;

   localparam logic [7:0] LEVEL_PERSIST = 8'd255;
   localparam logic [7:0] LEVEL_TOP     = 8'd254;
   localparam logic [4:0] BASE_CAP_RESET = 5'd8;
   localparam logic [4:0] EXTRA_MAX      = 5'd31;

   // request codes
   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_ERASE  = 3'd1;
   localparam logic [2:0] ACT_QUERY  = 3'd2;
   localparam logic [2:0] ACT_RESET  = 3'd3;
   localparam logic [2:0] ACT_NEWEST = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_REMOVE,
      ST_INS_PREP,
      ST_INSERT,
      ST_PUT,
      ST_FETCH,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic remove;
      logic ins_prep;
      logic insert;
      logic put;
      logic fetch;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rm_done;
      logic ins_done;
   } dp_status_type;

endpackage

FILE: rtl/core/checkpoint_slot_replacement.sv
// Steps: scan, decide, shift-down, insert prep, shift-up, put, fetch and reply; the scan
//   and both shifts walk the table entries, and the other steps are single states.
// Throughput: one word at a time, paced by the slot memory with one read and one write port
//   (one entry per cycle); busy stays high through the reply strobe, the next word goes in after it.
// Reset: synchronous, active high; table empties, capacity back to base 8.
// The reply is shown for one cycle on rsp_valid; the receiver cannot stall.
module checkpoint_slot_replacement
   import cpsr_pkg::*;
#(
   parameter int MaxSlots = MAX_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_step,
   input  logic        req_persistent,
   // reply channel
   output logic        rsp_valid,
   output logic        rsp_evicted_valid,
   output logic [31:0] rsp_evicted_step,
   output logic        rsp_found,
   output logic [31:0] rsp_newest_step,
   output logic [4:0]  rsp_entry_count,
   output logic [4:0]  rsp_capacity_now,
   output logic        rsp_refused,
   // base capacity register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_base_capacity
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register writes must only arrive while idle; the block does not enforce this and always takes them
   assign csr_ready = 1'b1;

   cpsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   cpsr_dpath #(
      .MaxSlots (MaxSlots)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_valid && csr_ready),
      .csr_base_capacity (csr_base_capacity),
      .req_action        (req_action),
      .req_step          (req_step),
      .req_persistent    (req_persistent),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_step  (rsp_evicted_step),
      .rsp_found         (rsp_found),
      .rsp_newest_step   (rsp_newest_step),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_capacity_now  (rsp_capacity_now),
      .rsp_refused       (rsp_refused)
   );

endmodule

FILE: rtl/core/cpsr_ctrl.sv
// Sequencer of the checkpoint slot table: one request at a time.
// Depends on cpsr_pkg for the state type and the command/status structs.
module cpsr_ctrl
   import cpsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (start) state_in = ST_SCAN;
         ST_SCAN:     if (status.scan_done) state_in = ST_DECIDE;
         ST_DECIDE:   state_in = ST_REMOVE;
         ST_REMOVE:   if (status.rm_done) state_in = ST_INS_PREP;
         ST_INS_PREP: state_in = ST_INSERT;
         ST_INSERT:   if (status.ins_done) state_in = ST_PUT;
         ST_PUT:      state_in = ST_FETCH;
         ST_FETCH:    state_in = ST_REPLY;
         ST_REPLY:    state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN:     cmd.scan     = 1'b1;
         ST_DECIDE:   cmd.decide   = 1'b1;
         ST_REMOVE:   cmd.remove   = 1'b1;
         ST_INS_PREP: cmd.ins_prep = 1'b1;
         ST_INSERT:   cmd.insert   = 1'b1;
         ST_PUT:      cmd.put      = 1'b1;
         ST_FETCH:    cmd.fetch    = 1'b1;
         ST_REPLY:    rsp_valid    = 1'b1;
         default:     busy         = 1'b1;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_reply_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPLY |=> state_ff == ST_IDLE)
      else $error("reply strobe held past one cycle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");
   a_decide_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> $past(state_ff) == ST_SCAN)
      else $error("decide entered out of order");
`endif

endmodule

FILE: rtl/core/cpsr_dpath.sv
// Datapath of the checkpoint slot table: slot memory, scan, shift engine.
// Depends on cpsr_pkg; driven by cpsr_ctrl commands.
module cpsr_dpath
   import cpsr_pkg::*;
#(
   parameter int MaxSlots = MAX_SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          csr_we,
   input  logic [4:0]    csr_base_capacity,
   input  logic [2:0]    req_action,
   input  logic [31:0]   req_step,
   input  logic          req_persistent,
   output logic          rsp_evicted_valid,
   output logic [31:0]   rsp_evicted_step,
   output logic          rsp_found,
   output logic [31:0]   rsp_newest_step,
   output logic [4:0]    rsp_entry_count,
   output logic [4:0]    rsp_capacity_now,
   output logic          rsp_refused
);

   localparam int IW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
   localparam int CW = $clog2(MaxSlots + 1);
   localparam int SW = CW + 6;
   localparam logic [CW-1:0] MAX_CNT = CW'(MaxSlots);

   // slot memory: {level, step}
   logic [39:0] mem [MaxSlots];
   logic [39:0] rdata_ff;
   logic [IW-1:0] raddr, waddr;
   logic [39:0] wdata;
   logic we;

   logic [CW-1:0] count_ff;
   logic [4:0]    extra_ff, base_ff;
   logic [CW-1:0] ptr_ff, wptr_ff;
   logic          rv_ff;
   logic [IW-1:0] ridx_ff;

   logic [2:0]  act_ff;
   logic [31:0] step_ff;
   logic        pers_ff;

   // scan results
   logic          match_ff, mpers_ff, hit_ff, pf_ff;
   logic [IW-1:0] midx_ff, victim_ff, pidx_ff;
   logic [CW-1:0] pos_ff;
   logic [7:0]    maxl_ff, lvl0_ff;
   logic [31:0]   vstep_ff, step0_ff;

   // plan registers
   logic          do_rm_ff, do_ins_ff;
   logic [CW-1:0] rm_dist_ff, ins_pos_ff;
   logic [7:0]    ins_lvl_ff;
   logic          ev_valid_ff, found_ff, refused_ff;
   logic [31:0]   ev_step_ff;

   logic [31:0] rd_step;
   logic [7:0]  rd_lvl;
   logic [CW-1:0] ptr_m1;
   logic fwd_issue, back_issue;

   assign rd_step    = rdata_ff[31:0];
   assign rd_lvl     = rdata_ff[39:32];
   assign ptr_m1     = ptr_ff - 1'b1;
   assign fwd_issue  = ptr_ff < count_ff;
   assign back_issue = ptr_ff > ins_pos_ff;

   // capacity from a given extra count
   logic [SW-1:0] base_c;
   always_comb begin
      base_c = (base_ff == 5'd0) ? SW'(1) : SW'(base_ff);
      if (base_c > SW'(MaxSlots)) base_c = SW'(MaxSlots);
   end

   function automatic logic [SW-1:0] cap_of(input logic [SW-1:0] b, input logic [4:0] x);
      logic [SW-1:0] s;
      s = b + SW'(x);
      if (s > SW'(MaxSlots)) s = SW'(MaxSlots);
      return s;
   endfunction

   // plan, from scan results
   logic          p_do_rm, p_do_ins, p_ev, p_found, p_ref;
   logic [CW-1:0] p_rm_pos, p_dist, p_ins_pos;
   logic [7:0]    p_lvl;
   logic [31:0]   p_ev_step;
   logic [4:0]    p_extra;
   logic [IW-1:0] p_victim;

   always_comb begin
      p_do_rm   = 1'b0;
      p_do_ins  = 1'b0;
      p_ev      = 1'b0;
      p_found   = 1'b0;
      p_ref     = 1'b0;
      p_rm_pos  = '0;
      p_dist    = CW'(1);
      p_ins_pos = pos_ff;
      p_lvl     = 8'd0;
      p_ev_step = 32'd0;
      p_extra   = extra_ff;
      p_victim  = hit_ff ? victim_ff : '0;
      case (act_ff)
         ACT_ADD: begin
            if (!match_ff) begin
               if (pers_ff && count_ff == MAX_CNT) begin
                  p_ref = 1'b1;
               end else begin
                  if (pers_ff && extra_ff != EXTRA_MAX) p_extra = extra_ff + 5'd1;
                  p_do_ins = 1'b1;
                  p_lvl    = pers_ff ? LEVEL_PERSIST : 8'd0;
                  if (SW'(count_ff) >= cap_of(base_c, p_extra)) begin
                     // evict, then insert into the shortened table
                     p_do_rm   = 1'b1;
                     p_ev      = 1'b1;
                     p_rm_pos  = CW'(p_victim);
                     p_ev_step = hit_ff ? vstep_ff : step0_ff;
                     if (!pers_ff && !hit_ff)
                        p_lvl = (lvl0_ff >= LEVEL_TOP) ? LEVEL_TOP : lvl0_ff + 8'd1;
                     if (CW'(p_victim) < pos_ff) p_ins_pos = pos_ff - 1'b1;
                  end
               end
            end
         end
         ACT_ERASE: begin
            if (match_ff && !mpers_ff) begin
               p_do_rm  = 1'b1;
               p_rm_pos = CW'(midx_ff);
               p_found  = 1'b1;
            end
         end
         ACT_QUERY: p_found = match_ff;
         ACT_RESET: begin
            if (pf_ff && pidx_ff != '0) begin
               p_do_rm = 1'b1;
               p_dist  = CW'(pidx_ff);
            end
         end
         default: p_found = 1'b0;
      endcase
   end

   // memory port selection
   always_comb begin
      raddr = ptr_ff[IW-1:0];
      we    = 1'b0;
      waddr = wptr_ff[IW-1:0];
      wdata = rdata_ff;
      if (cmd.insert) begin
         raddr = ptr_m1[IW-1:0];
         waddr = ridx_ff + 1'b1;
         we    = rv_ff;
      end else if (cmd.remove) begin
         we = rv_ff;
      end else if (cmd.put) begin
         waddr = ins_pos_ff[IW-1:0];
         wdata = {ins_lvl_ff, step_ff};
         we    = do_ins_ff;
      end else if (cmd.fetch) begin
         raddr = '0;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (we) mem[waddr] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         extra_ff <= '0;
         base_ff  <= BASE_CAP_RESET;
         rv_ff    <= 1'b0;
      end else begin
         if (csr_we) base_ff <= csr_base_capacity;
         if (cmd.load) begin
            act_ff   <= req_action;
            step_ff  <= req_step;
            pers_ff  <= req_persistent;
            ptr_ff   <= '0;
            rv_ff    <= 1'b0;
            match_ff <= 1'b0;
            mpers_ff <= 1'b0;
            hit_ff   <= 1'b0;
            pf_ff    <= 1'b0;
            pos_ff   <= '0;
            maxl_ff  <= 8'd0;
            midx_ff  <= '0;
            pidx_ff  <= '0;
            victim_ff <= '0;
            vstep_ff <= 32'd0;
            lvl0_ff  <= 8'd0;
            step0_ff <= 32'd0;
         end
         if (cmd.scan) begin
            rv_ff   <= fwd_issue;
            ridx_ff <= ptr_ff[IW-1:0];
            if (fwd_issue) ptr_ff <= ptr_ff + 1'b1;
            if (rv_ff) begin
               if (rd_step == step_ff && !match_ff) begin
                  match_ff <= 1'b1;
                  midx_ff  <= ridx_ff;
                  mpers_ff <= rd_lvl == LEVEL_PERSIST;
               end
               if (rd_step > step_ff) pos_ff <= pos_ff + 1'b1;
               if (!hit_ff) begin
                  if (rd_lvl < maxl_ff) begin
                     hit_ff    <= 1'b1;
                     victim_ff <= ridx_ff;
                     vstep_ff  <= rd_step;
                  end else if (rd_lvl > maxl_ff) begin
                     maxl_ff <= rd_lvl;
                  end
               end
               if (ridx_ff == '0) begin
                  lvl0_ff  <= rd_lvl;
                  step0_ff <= rd_step;
               end
               if (rd_lvl == LEVEL_PERSIST && !pf_ff) begin
                  pf_ff   <= 1'b1;
                  pidx_ff <= ridx_ff;
               end
            end
         end
         if (cmd.decide) begin
            do_rm_ff    <= p_do_rm;
            do_ins_ff   <= p_do_ins;
            rm_dist_ff  <= p_dist;
            ins_pos_ff  <= p_ins_pos;
            ins_lvl_ff  <= p_lvl;
            ev_valid_ff <= p_ev;
            ev_step_ff  <= p_ev_step;
            found_ff    <= p_found;
            refused_ff  <= p_ref;
            extra_ff    <= p_extra;
            ptr_ff      <= p_rm_pos + p_dist;
            wptr_ff     <= p_rm_pos;
            rv_ff       <= 1'b0;
         end
         if (cmd.remove && do_rm_ff) begin
            rv_ff <= fwd_issue;
            if (fwd_issue) ptr_ff <= ptr_ff + 1'b1;
            if (rv_ff) wptr_ff <= wptr_ff + 1'b1;
            if (status.rm_done) count_ff <= count_ff - rm_dist_ff;
         end
         if (cmd.ins_prep) begin
            ptr_ff <= count_ff;
            rv_ff  <= 1'b0;
         end
         if (cmd.insert && do_ins_ff) begin
            rv_ff   <= back_issue;
            ridx_ff <= ptr_m1[IW-1:0];
            if (back_issue) ptr_ff <= ptr_m1;
         end
         if (cmd.put && do_ins_ff) count_ff <= count_ff + 1'b1;
      end
   end

   assign status.scan_done = !fwd_issue && !rv_ff;
   assign status.rm_done   = !do_rm_ff || (!fwd_issue && !rv_ff);
   assign status.ins_done  = !do_ins_ff || (!back_issue && !rv_ff);

   assign rsp_evicted_valid = ev_valid_ff;
   assign rsp_evicted_step  = ev_step_ff;
   assign rsp_found         = found_ff;
   assign rsp_refused       = refused_ff;
   assign rsp_newest_step   = (count_ff != '0) ? rd_step : 32'd0;
   assign rsp_entry_count   = 5'(count_ff);
   assign rsp_capacity_now  = 5'(cap_of(base_c, extra_ff));

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count beyond table size");
   a_put_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.put && do_ins_ff) |-> count_ff < MAX_CNT)
      else $error("insert into a full table");
   a_refuse_clean: assert property (@(posedge clock) disable iff (reset)
      cmd.put && refused_ff |-> !ev_valid_ff && !do_ins_ff && !do_rm_ff)
      else $error("refused add changed the table");
`endif

endmodule
